// ===== design/spt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spt_pkg
// Shared types and codes for the script push tokenizer: transfer records,
// byte classes, parse modes, token kinds and error codes.
// ----------------------------------------------------------------------------
package spt_pkg;

   // default bound on a script's length and depth of the internal queues
   localparam logic [31:0] SPT_MAX_SCRIPT_LEN = 32'd65535;
   localparam int          SPT_QUEUE_DEPTH    = 2;

   // token kinds
   localparam logic [2:0] KIND_OPCODE  = 3'd0;
   localparam logic [2:0] KIND_HEADER  = 3'd1;
   localparam logic [2:0] KIND_DATA    = 3'd2;
   localparam logic [2:0] KIND_ERROR   = 3'd3;
   localparam logic [2:0] KIND_IGNORED = 3'd4;

   // error codes
   localparam logic [1:0] ERR_NONE       = 2'd0;
   localparam logic [1:0] ERR_SIZE_TRUNC = 2'd1;
   localparam logic [1:0] ERR_OVERRUN    = 2'd2;

   // push opcodes
   localparam logic [7:0] OP_DIRECT_MIN = 8'h01;
   localparam logic [7:0] OP_DIRECT_MAX = 8'h4b;
   localparam logic [7:0] OP_PUSH_LEN8  = 8'h4c;
   localparam logic [7:0] OP_PUSH_LEN16 = 8'h4d;
   localparam logic [7:0] OP_PUSH_LEN32 = 8'h4e;

   typedef enum logic [1:0] {
      CLS_OPCODE,
      CLS_DIRECT,
      CLS_PUSHDATA
   } spt_class_type;

   typedef enum logic [1:0] {
      MODE_OPCODE,
      MODE_SIZE,
      MODE_DATA,
      MODE_ABORT
   } spt_mode_type;

   typedef struct packed {
      logic [7:0]  script_byte;
      logic        first_of_script;
      logic [15:0] script_length;
   } spt_req_type;

   typedef struct packed {
      logic [2:0]  token_kind;
      logic [7:0]  byte_value;
      logic [31:0] push_size;
      logic        size_known;
      logic        last_of_push;
      logic [1:0]  error_code;
   } spt_rsp_type;

   // classified byte as it travels from the front to the back
   typedef struct packed {
      logic [7:0]    script_byte;
      logic          first_of_script;
      logic [15:0]   script_length;
      spt_class_type byte_class;
      logic [2:0]    field_bytes;
   } spt_item_type;

endpackage

// ===== design/spt_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spt_fifo
// Small register queue with full and empty flags decoded from a registered count.
// ----------------------------------------------------------------------------
module spt_fifo
   import spt_pkg::*;
#(
   parameter int WIDTH = 1,
   parameter int DEPTH = SPT_QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wr_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rd_data,
   output logic             empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   logic [WIDTH-1:0] slots_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   // transfer qualification
   assign full    = (count_ff == CNT_FULL);
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rd_data = slots_ff[rd_ptr_ff];

   // pointer and count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // slot storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

// ===== design/spt_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spt_front
// Accepts script bytes, normalizes the script length, classifies each byte
// as opcode, direct push or pushdata header and queues it for the back end.
// ----------------------------------------------------------------------------
module spt_front
   import spt_pkg::*;
#(
   parameter logic [31:0] MAX_SCRIPT_LEN = SPT_MAX_SCRIPT_LEN,
   parameter int          QUEUE_DEPTH    = SPT_QUEUE_DEPTH
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_push,
   output logic         req_full,
   input  spt_req_type  req_data,
   output logic         item_valid,
   input  logic         item_pop,
   output spt_item_type item
);

   // length cap as seen by a 16-bit length field
   localparam logic [15:0] LEN_CAP =
      (MAX_SCRIPT_LEN > 32'd65535) ? 16'hffff : MAX_SCRIPT_LEN[15:0];

   spt_item_type                        item_new;
   logic [$bits(spt_item_type)-1:0]     item_bits;
   logic                                item_empty;

   // length normalization and byte classification
   always_comb begin
      item_new.script_byte     = req_data.script_byte;
      item_new.first_of_script = req_data.first_of_script;
      item_new.script_length   = req_data.script_length;
      item_new.byte_class      = CLS_OPCODE;
      item_new.field_bytes     = 3'd0;
      if (req_data.script_length == 16'd0) begin
         item_new.script_length = 16'd1;
      end else if (req_data.script_length > LEN_CAP) begin
         item_new.script_length = LEN_CAP;
      end
      if (req_data.script_byte >= OP_DIRECT_MIN && req_data.script_byte <= OP_DIRECT_MAX) begin
         item_new.byte_class = CLS_DIRECT;
      end else if (req_data.script_byte == OP_PUSH_LEN8) begin
         item_new.byte_class  = CLS_PUSHDATA;
         item_new.field_bytes = 3'd1;
      end else if (req_data.script_byte == OP_PUSH_LEN16) begin
         item_new.byte_class  = CLS_PUSHDATA;
         item_new.field_bytes = 3'd2;
      end else if (req_data.script_byte == OP_PUSH_LEN32) begin
         item_new.byte_class  = CLS_PUSHDATA;
         item_new.field_bytes = 3'd4;
      end
   end

   // queue toward the parser
   spt_fifo #(
      .WIDTH ($bits(spt_item_type)),
      .DEPTH (QUEUE_DEPTH)
   ) u_item_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (req_push),
      .wr_data (item_new),
      .full    (req_full),
      .pop     (item_pop),
      .rd_data (item_bits),
      .empty   (item_empty)
   );

   assign item_valid = !item_empty;
   assign item       = spt_item_type'(item_bits);

endmodule

// ===== design/spt_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spt_back
// Parse state machine: tracks script and push byte counts, assembles
// pushdata size fields, labels each byte and queues the result.
// ----------------------------------------------------------------------------
module spt_back
   import spt_pkg::*;
#(
   parameter int QUEUE_DEPTH = SPT_QUEUE_DEPTH
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         item_valid,
   input  spt_item_type item,
   output logic         item_pop,
   output logic         rsp_empty,
   input  logic         rsp_pop,
   output spt_rsp_type  rsp_data
);

   spt_mode_type mode_ff, mode_in, cur_mode;
   logic [15:0]  bytes_left_ff, bytes_left_in, cur_bytes_left, rem;
   logic [2:0]   size_left_ff, size_left_in, cur_size_left, size_left_dec;
   logic [31:0]  acc_ff, acc_in, cur_acc, acc_merged;
   logic [1:0]   idx_ff, idx_in, cur_idx;
   logic [31:0]  data_left_ff, data_left_in, cur_data_left, data_dec;
   logic         take, out_full;
   logic         direct_over, field_over, size_over, size_done, data_done;
   logic [7:0]   b;
   spt_rsp_type  rsp_new;
   logic [$bits(spt_rsp_type)-1:0] rsp_bits;

   assign take     = item_valid && !out_full;
   assign item_pop = take;
   assign b        = item.script_byte;

   // state as seen by this byte: a first byte restarts the parse
   always_comb begin
      if (item.first_of_script) begin
         cur_bytes_left = item.script_length;
         cur_mode       = MODE_OPCODE;
         cur_size_left  = 3'd0;
         cur_acc        = 32'd0;
         cur_idx        = 2'd0;
         cur_data_left  = 32'd0;
      end else begin
         cur_bytes_left = bytes_left_ff;
         cur_mode       = mode_ff;
         cur_size_left  = size_left_ff;
         cur_acc        = acc_ff;
         cur_idx        = idx_ff;
         cur_data_left  = data_left_ff;
      end
   end

   // shared counts and bounds checks
   always_comb begin
      rem           = cur_bytes_left - 16'd1;
      direct_over   = {8'd0, b} > rem;
      field_over    = {13'd0, item.field_bytes} > rem;
      size_left_dec = (cur_size_left != 3'd0) ? cur_size_left - 3'd1 : 3'd0;
      size_done     = (size_left_dec == 3'd0);
      data_dec      = (cur_data_left != 32'd0) ? cur_data_left - 32'd1 : 32'd0;
      data_done     = (data_dec == 32'd0);
      case (cur_idx)
         2'd0:    acc_merged = cur_acc | {24'd0, b};
         2'd1:    acc_merged = cur_acc | {16'd0, b, 8'd0};
         2'd2:    acc_merged = cur_acc | {8'd0, b, 16'd0};
         default: acc_merged = cur_acc | {b, 24'd0};
      endcase
      size_over = acc_merged > {16'd0, rem};
   end

   // next state
   always_comb begin
      bytes_left_in = cur_bytes_left;
      mode_in       = cur_mode;
      size_left_in  = cur_size_left;
      acc_in        = cur_acc;
      idx_in        = cur_idx;
      data_left_in  = cur_data_left;
      if (cur_bytes_left != 16'd0) begin
         bytes_left_in = rem;
         unique case (cur_mode)
            MODE_OPCODE: begin
               if (item.byte_class == CLS_DIRECT) begin
                  if (direct_over) begin
                     mode_in = MODE_ABORT;
                  end else begin
                     data_left_in = {24'd0, b};
                     mode_in      = MODE_DATA;
                  end
               end else if (item.byte_class == CLS_PUSHDATA) begin
                  if (field_over) begin
                     mode_in = MODE_ABORT;
                  end else begin
                     size_left_in = item.field_bytes;
                     acc_in       = 32'd0;
                     idx_in       = 2'd0;
                     mode_in      = MODE_SIZE;
                  end
               end
            end
            MODE_SIZE: begin
               acc_in       = acc_merged;
               idx_in       = cur_idx + 2'd1;
               size_left_in = size_left_dec;
               if (size_done) begin
                  if (size_over) begin
                     mode_in = MODE_ABORT;
                  end else if (acc_merged == 32'd0) begin
                     mode_in = MODE_OPCODE;
                  end else begin
                     data_left_in = acc_merged;
                     mode_in      = MODE_DATA;
                  end
               end
            end
            MODE_DATA: begin
               data_left_in = data_dec;
               if (data_done) begin
                  mode_in = MODE_OPCODE;
               end
            end
            MODE_ABORT: begin
               mode_in = MODE_ABORT;
            end
            default: begin
               mode_in = MODE_ABORT;
            end
         endcase
      end
   end

   // result labeling
   always_comb begin
      rsp_new.token_kind   = KIND_IGNORED;
      rsp_new.byte_value   = b;
      rsp_new.push_size    = 32'd0;
      rsp_new.size_known   = 1'b0;
      rsp_new.last_of_push = 1'b0;
      rsp_new.error_code   = ERR_NONE;
      if (cur_bytes_left != 16'd0) begin
         unique case (cur_mode)
            MODE_OPCODE: begin
               if (item.byte_class == CLS_DIRECT) begin
                  rsp_new.size_known = 1'b1;
                  rsp_new.push_size  = {24'd0, b};
                  if (direct_over) begin
                     rsp_new.token_kind = KIND_ERROR;
                     rsp_new.error_code = ERR_OVERRUN;
                  end else begin
                     rsp_new.token_kind = KIND_HEADER;
                  end
               end else if (item.byte_class == CLS_PUSHDATA) begin
                  if (field_over) begin
                     rsp_new.token_kind = KIND_ERROR;
                     rsp_new.error_code = ERR_SIZE_TRUNC;
                  end else begin
                     rsp_new.token_kind = KIND_HEADER;
                  end
               end else begin
                  rsp_new.token_kind = KIND_OPCODE;
               end
            end
            MODE_SIZE: begin
               rsp_new.token_kind = KIND_HEADER;
               if (size_done) begin
                  rsp_new.size_known = 1'b1;
                  rsp_new.push_size  = acc_merged;
                  if (size_over) begin
                     rsp_new.token_kind = KIND_ERROR;
                     rsp_new.error_code = ERR_OVERRUN;
                  end else if (acc_merged == 32'd0) begin
                     rsp_new.last_of_push = 1'b1;
                  end
               end
            end
            MODE_DATA: begin
               rsp_new.token_kind   = KIND_DATA;
               rsp_new.last_of_push = data_done;
            end
            MODE_ABORT: begin
               rsp_new.token_kind = KIND_IGNORED;
            end
            default: begin
               rsp_new.token_kind = KIND_IGNORED;
            end
         endcase
      end
   end

   // parse state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= MODE_OPCODE;
         bytes_left_ff <= '0;
         size_left_ff  <= '0;
         acc_ff        <= '0;
         idx_ff        <= '0;
         data_left_ff  <= '0;
      end else if (take) begin
         mode_ff       <= mode_in;
         bytes_left_ff <= bytes_left_in;
         size_left_ff  <= size_left_in;
         acc_ff        <= acc_in;
         idx_ff        <= idx_in;
         data_left_ff  <= data_left_in;
      end
   end

   // result queue
   spt_fifo #(
      .WIDTH ($bits(spt_rsp_type)),
      .DEPTH (QUEUE_DEPTH)
   ) u_rsp_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (take),
      .wr_data (rsp_new),
      .full    (out_full),
      .pop     (rsp_pop),
      .rd_data (rsp_bits),
      .empty   (rsp_empty)
   );

   assign rsp_data = spt_rsp_type'(rsp_bits);

   // size field mode always has bytes still to come
   a_size_left_live: assert property (@(posedge clock) disable iff (reset)
      mode_ff == MODE_SIZE |-> size_left_ff != 3'd0)
      else $error("size field mode with no size bytes left");

   // data mode always has data still to come
   a_data_left_live: assert property (@(posedge clock) disable iff (reset)
      mode_ff == MODE_DATA |-> data_left_ff != 32'd0)
      else $error("data mode with no data bytes left");

   // an accepted push never reaches past the end of its script
   a_data_fits: assert property (@(posedge clock) disable iff (reset)
      mode_ff == MODE_DATA |-> data_left_ff <= {16'd0, bytes_left_ff})
      else $error("push data runs past the script");

   // the final data byte of a push returns the parser to opcodes
   a_push_ends: assert property (@(posedge clock) disable iff (reset)
      take && !item.first_of_script && mode_ff == MODE_DATA &&
      data_left_ff == 32'd1 && bytes_left_ff != 16'd0 |=> mode_ff == MODE_OPCODE)
      else $error("parser did not leave data mode after last push byte");

endmodule

// ===== design/script_push_tokenizer_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// script_push_tokenizer_core
// Labels each byte of a script as opcode, push header, push data, error or
// ignored, and reports declared push sizes.
//
// Path: a byte transferred in is held in the classify queue, then parsed
// into the result queue. Throughput: one byte per cycle while neither queue
// is full, with the parse state updated once per accepted byte.
// Reset: synchronous; clears both queues and the parse state to opcode mode
// with no bytes left in the script.
// ----------------------------------------------------------------------------
module script_push_tokenizer_core
   import spt_pkg::*;
#(
   parameter logic [31:0] MAX_SCRIPT_LEN = SPT_MAX_SCRIPT_LEN,
   parameter int          QUEUE_DEPTH    = SPT_QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  spt_req_type req_data,
   output logic        empty,
   input  logic        pop,
   output spt_rsp_type rsp_data
);

   spt_item_type item;
   logic         item_valid;
   logic         item_pop;

   // classification front end
   spt_front #(
      .MAX_SCRIPT_LEN (MAX_SCRIPT_LEN),
      .QUEUE_DEPTH    (QUEUE_DEPTH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_push   (push),
      .req_full   (full),
      .req_data   (req_data),
      .item_valid (item_valid),
      .item_pop   (item_pop),
      .item       (item)
   );

   // parse back end
   spt_back #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .item       (item),
      .item_pop   (item_pop),
      .rsp_empty  (empty),
      .rsp_pop    (pop),
      .rsp_data   (rsp_data)
   );

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the script push tokenizer. Directed scripts hit
// each kind of token and every abort path. Random scripts follow: mostly
// well-formed pushes and opcodes, plus cut-short scripts, stray bytes and
// noise. A local predictor labels every transferred byte, and each popped
// token is checked field by field against the oldest predicted one.
// Both sides idle at random.
// ----------------------------------------------------------------------------
module tb;
   import spt_pkg::*;

   localparam int RANDOM_ITEMS = 1100;
   localparam int RUN_LIMIT    = 200000;
   localparam int DRAIN_CYCLES = 20;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        push = 1'b0;
   logic        full;
   spt_req_type req_data = '0;
   logic        empty;
   logic        pop = 1'b0;
   spt_rsp_type rsp_data;

   // predicted tokens, oldest first
   spt_rsp_type pending_tokens[$];
   logic [7:0]  script_bytes[$];

   int in_max_gap = 4;
   int out_max_gap = 4;
   int error_count = 0;
   int token_count = 0;
   int cycle_count = 0;

   // predictor state
   logic [15:0]  script_left = '0;
   spt_mode_type parse_state = MODE_OPCODE;
   logic [2:0]   field_left = '0;
   logic [31:0]  size_sum = '0;
   logic [1:0]   field_pos = '0;
   logic [31:0]  data_left = '0;

   script_push_tokenizer_core i_dut (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .full     (full),
      .req_data (req_data),
      .empty    (empty),
      .pop      (pop),
      .rsp_data (rsp_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == RUN_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // label one byte and advance the predictor
   function automatic spt_rsp_type label_byte(spt_req_type item);
      spt_rsp_type tok;
      logic [15:0] rest;
      logic [15:0] len16;
      logic [2:0]  field_n;
      tok = '0;
      tok.token_kind = KIND_IGNORED;
      tok.byte_value = item.script_byte;
      tok.error_code = ERR_NONE;
      if (item.first_of_script) begin
         len16 = (item.script_length == 16'd0) ? 16'd1 : item.script_length;
         if (32'(len16) > SPT_MAX_SCRIPT_LEN) len16 = SPT_MAX_SCRIPT_LEN[15:0];
         script_left = len16;
         parse_state = MODE_OPCODE;
         field_left = '0;
         size_sum = '0;
         field_pos = '0;
         data_left = '0;
      end
      // stray byte past the end of the script
      if (script_left == 16'd0) return tok;
      rest = script_left - 16'd1;
      case (parse_state)
         MODE_OPCODE: begin
            if (item.script_byte >= OP_DIRECT_MIN && item.script_byte <= OP_DIRECT_MAX) begin
               tok.size_known = 1'b1;
               tok.push_size = 32'(item.script_byte);
               if (16'(item.script_byte) > rest) begin
                  tok.token_kind = KIND_ERROR;
                  tok.error_code = ERR_OVERRUN;
                  parse_state = MODE_ABORT;
               end else begin
                  tok.token_kind = KIND_HEADER;
                  data_left = 32'(item.script_byte);
                  parse_state = MODE_DATA;
               end
            end else if (item.script_byte >= OP_PUSH_LEN8 &&
                         item.script_byte <= OP_PUSH_LEN32) begin
               field_n = (item.script_byte == OP_PUSH_LEN8) ? 3'd1 :
                         (item.script_byte == OP_PUSH_LEN16) ? 3'd2 : 3'd4;
               if (16'(field_n) > rest) begin
                  tok.token_kind = KIND_ERROR;
                  tok.error_code = ERR_SIZE_TRUNC;
                  parse_state = MODE_ABORT;
               end else begin
                  tok.token_kind = KIND_HEADER;
                  field_left = field_n;
                  size_sum = '0;
                  field_pos = '0;
                  parse_state = MODE_SIZE;
               end
            end else begin
               tok.token_kind = KIND_OPCODE;
            end
         end
         MODE_SIZE: begin
            // little-endian size field
            size_sum = size_sum | (32'(item.script_byte) << {field_pos, 3'b000});
            field_pos = field_pos + 2'd1;
            if (field_left != 3'd0) field_left = field_left - 3'd1;
            tok.token_kind = KIND_HEADER;
            if (field_left == 3'd0) begin
               tok.size_known = 1'b1;
               tok.push_size = size_sum;
               if (size_sum > 32'(rest)) begin
                  tok.token_kind = KIND_ERROR;
                  tok.error_code = ERR_OVERRUN;
                  parse_state = MODE_ABORT;
               end else if (size_sum == 32'd0) begin
                  tok.last_of_push = 1'b1;
                  parse_state = MODE_OPCODE;
               end else begin
                  data_left = size_sum;
                  parse_state = MODE_DATA;
               end
            end
         end
         MODE_DATA: begin
            tok.token_kind = KIND_DATA;
            if (data_left != 32'd0) data_left = data_left - 32'd1;
            if (data_left == 32'd0) begin
               tok.last_of_push = 1'b1;
               parse_state = MODE_OPCODE;
            end
         end
         default: begin
            tok.token_kind = KIND_IGNORED;
         end
      endcase
      script_left = rest;
      return tok;
   endfunction

   // one byte transfer in, with a random gap first
   task automatic send_byte(input logic [7:0] value, input logic starts,
                            input logic [15:0] len16);
      spt_req_type item;
      int gap;
      item.script_byte = value;
      item.first_of_script = starts;
      item.script_length = len16;
      gap = $urandom_range(0, in_max_gap);
      if (gap > 0) begin
         push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      push <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (full);
      pending_tokens.push_back(label_byte(item));
   endtask

   // send the first count bytes of script_bytes as one script
   task automatic send_script(input logic [15:0] declared, input int count);
      for (int i = 0; i < count; i++) begin
         send_byte(script_bytes[i], i == 0, (i == 0) ? declared : 16'($urandom));
      end
   endtask

   // well-formed script of exactly len bytes
   task automatic build_clean_script(input int len);
      int room;
      int pick;
      int n;
      int field_n;
      int cap;
      script_bytes = {};
      while (script_bytes.size() < len) begin
         room = len - script_bytes.size() - 1;
         pick = $urandom_range(0, 3);
         cap = ($urandom_range(0, 15) == 0) ? 75 : 12;
         field_n = (pick == 2) ? 1 : (pick == 3) ? (($urandom_range(0, 1) == 0) ? 2 : 4) : 0;
         if (pick == 0 || room == 0 || field_n > room) begin
            if ($urandom_range(0, 3) == 0) script_bytes.push_back(8'h00);
            else script_bytes.push_back(8'($urandom_range(32'h4f, 32'hff)));
         end else if (pick == 1) begin
            n = $urandom_range(1, (room < cap) ? room : cap);
            script_bytes.push_back(8'(n));
            repeat (n) script_bytes.push_back(8'($urandom));
         end else begin
            n = $urandom_range(0, (room - field_n < cap) ? room - field_n : cap);
            script_bytes.push_back((field_n == 1) ? OP_PUSH_LEN8 :
                                   (field_n == 2) ? OP_PUSH_LEN16 : OP_PUSH_LEN32);
            for (int k = 0; k < field_n; k++) script_bytes.push_back(8'(n >> (8 * k)));
            repeat (n) script_bytes.push_back(8'($urandom));
         end
      end
   endtask

   // random bytes, biased toward the pushdata headers
   task automatic build_noise_script(input int len);
      script_bytes = {};
      repeat (len) begin
         if ($urandom_range(0, 7) == 0)
            script_bytes.push_back(8'(OP_PUSH_LEN8 + $urandom_range(0, 2)));
         else
            script_bytes.push_back(8'($urandom));
      end
   endtask

   // checker: pop with random stalls and compare against the oldest prediction
   initial begin
      spt_rsp_type want;
      spt_rsp_type got;
      int gap;
      do @(posedge clock); while (reset);
      forever begin
         if ($urandom_range(0, 63) == 0) out_max_gap = ($urandom_range(0, 2) == 0) ? 0 : 4;
         gap = $urandom_range(0, out_max_gap);
         if (gap > 0) begin
            pop <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         pop <= 1'b1;
         do @(posedge clock); while (empty);
         got = rsp_data;
         if (pending_tokens.size() == 0) begin
            error_count++;
            if (error_count <= 10)
               $display("token %0d: unexpected, got kind=%0d byte=%h", token_count,
                        got.token_kind, got.byte_value);
         end else begin
            want = pending_tokens.pop_front();
            if (got.token_kind !== want.token_kind || got.byte_value !== want.byte_value ||
                got.push_size !== want.push_size || got.size_known !== want.size_known ||
                got.last_of_push !== want.last_of_push ||
                got.error_code !== want.error_code) begin
               error_count++;
               if (error_count <= 10) begin
                  $write("token %0d: expected kind=%0d byte=%h size=%h known=%b last=%b ",
                         token_count, want.token_kind, want.byte_value, want.push_size,
                         want.size_known, want.last_of_push);
                  $write("err=%0d, got kind=%0d byte=%h size=%h ", want.error_code,
                         got.token_kind, got.byte_value, got.push_size);
                  $display("known=%b last=%b err=%0d", got.size_known, got.last_of_push,
                           got.error_code);
               end
            end
         end
         token_count++;
      end
   end

   // bytes before any script are ignored
   task automatic test_stray_bytes;
      send_byte(8'h00, 1'b0, 16'h0000);
      send_byte(8'hff, 1'b0, 16'hffff);
   endtask

   // op_0 and plain opcodes at both ends of the range
   task automatic test_plain_opcodes;
      script_bytes = {8'h00, 8'h4f, 8'hff};
      send_script(16'd3, 3);
   endtask

   // smallest direct push that fits, largest direct push that overruns
   task automatic test_direct_pushes;
      script_bytes = {OP_DIRECT_MIN, 8'ha5};
      send_script(16'd2, 2);
      script_bytes = {OP_DIRECT_MAX, 8'h00};
      send_script(16'd2, 2);
   endtask

   // empty push completes on the size byte
   task automatic test_empty_push;
      script_bytes = {OP_PUSH_LEN8, 8'h00};
      send_script(16'd2, 2);
   endtask

   // size equal to a pushdata opcode, then a new script cuts the push short
   task automatic test_pushdata_size_and_restart;
      script_bytes = {OP_PUSH_LEN8, OP_PUSH_LEN8, 8'h5a, 8'hc3};
      send_script(16'd80, 3);
      script_bytes = {8'hc3};
      send_script(16'd1, 1);
   endtask

   // four-byte size of all ones overruns the script
   task automatic test_overrun;
      script_bytes = {OP_PUSH_LEN32, 8'hff, 8'hff, 8'hff, 8'hff};
      send_script(16'd5, 5);
   endtask

   // size field runs past the end of the script
   task automatic test_truncated_size;
      script_bytes = {OP_PUSH_LEN16, 8'h01};
      send_script(16'd2, 2);
   endtask

   // zero length acts as one, next byte falls outside the script
   task automatic test_zero_length;
      send_byte(OP_PUSH_LEN8, 1'b1, 16'd0);
      send_byte(8'h77, 1'b0, 16'h1234);
   endtask

   // longest length the field can carry
   task automatic test_long_length;
      script_bytes = {OP_PUSH_LEN32};
      send_script(16'hffff, 1);
   endtask

   // mostly clean scripts, some cut short, overlong or noise
   task automatic test_random_scripts;
      int sent;
      int len;
      int variant;
      int count;
      int extra;
      logic [15:0] declared;
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         in_max_gap = ($urandom_range(0, 3) == 0) ? 0 : 4;
         len = ($urandom_range(0, 7) == 0) ? $urandom_range(41, 120) : $urandom_range(1, 40);
         variant = $urandom_range(0, 9);
         if (variant <= 7) build_clean_script(len);
         else build_noise_script(len);
         declared = 16'(len);
         count = len;
         if (variant == 6) begin
            count = $urandom_range(1, len);
         end else if (variant == 7) begin
            extra = $urandom_range(1, 3);
            repeat (extra) script_bytes.push_back(8'($urandom));
            count = len + extra;
         end else if (variant == 9) begin
            declared = 16'($urandom);
         end
         send_script(declared, count);
         sent += count;
      end
   endtask

   // main sequence
   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_stray_bytes();
      test_plain_opcodes();
      test_direct_pushes();
      test_empty_push();
      test_pushdata_size_and_restart();
      test_overrun();
      test_truncated_size();
      test_zero_length();
      test_long_length();
      test_random_scripts();
      push <= 1'b0;
      while (pending_tokens.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0 && pending_tokens.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
